>>> rtl/dfa_sm_pkg.sv
// dfa_sm_pkg: shared types and constants for the dfa string matcher
// request codes, transition table entry and command, result item layout
// no dependencies
`default_nettype none

package dfa_sm_pkg;

  // default sizing of the automaton
  localparam int NUM_STATES_DEF  = 64;
  localparam int NUM_SYMBOLS_DEF = 94;

  // field widths fixed by the item layout
  localparam int ST_W  = 6;
  localparam int SYM_W = 8;

  // first printable character code
  localparam logic [SYM_W-1:0] SYM_BASE = 8'd32;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_WR_TRANS = 2'd0,
    REQ_MARK     = 2'd1,
    REQ_MATCH    = 2'd2,
    REQ_EMPTY    = 2'd3
  } req_t;

  // one transition table entry
  typedef struct packed {
    logic            valid;
    logic [ST_W-1:0] dest;
  } tbl_entry_t;

  // control from the sequencer to the table memory
  typedef struct packed {
    logic       we;
    logic       re;
    tbl_entry_t wdata;
  } tbl_cmd_t;

  // result item, accepted in the lowest bit
  typedef struct packed {
    logic [ST_W-1:0] end_state;
    logic            bad_symbol;
    logic            accepted;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/dfa_sm_table.sv
// dfa_sm_table: transition table memory with registered read
// runs a clearing pass over every entry after reset; uses dfa_sm_pkg
`default_nettype none

module dfa_sm_table #(
  parameter int DEPTH = dfa_sm_pkg::NUM_STATES_DEF * dfa_sm_pkg::NUM_SYMBOLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dfa_sm_pkg::tbl_cmd_t   cmd,
  input  wire logic [AW-1:0]          addr,
  output dfa_sm_pkg::tbl_entry_t      rdata,
  output logic                        clr_busy
);

  dfa_sm_pkg::tbl_entry_t mem [DEPTH];
  dfa_sm_pkg::tbl_entry_t rdata_r;

  logic [AW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic                   clr_busy_r, clr_busy_nxt;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  dfa_sm_pkg::tbl_entry_t wr_data;

  // clearing pass sequencing
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_cnt_r  <= clr_cnt_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // write port shared between the clearing pass and table updates
  always_comb begin
    wr_en   = rst_n && (clr_busy_r || cmd.we);
    wr_addr = clr_busy_r ? clr_cnt_r : addr;
    wr_data = clr_busy_r ? '0 : cmd.wdata;
  end

  // memory array, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

>>> rtl/dfa_sm_out_buf.sv
// dfa_sm_out_buf: output register plus skid slot for result items
// decouples result delivery from the sequencer; uses dfa_sm_pkg
`default_nettype none

module dfa_sm_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire dfa_sm_pkg::result_t  push_data,
  output logic                      space,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata  // accepted, bad_symbol, end_state[5:0]
);

  logic                an_valid_r, an_valid_nxt;
  dfa_sm_pkg::result_t out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  dfa_sm_pkg::result_t skid_data_r, skid_data_nxt;
  logic                pop;

  assign pop = an_valid_r && out_tready;

  // refill the output register from the skid slot first, then from a new item
  always_comb begin
    an_valid_nxt   = an_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop || !an_valid_r) begin
      if (skid_valid_r) begin
        an_valid_nxt   = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = push;
        skid_data_nxt  = push_data;
      end else begin
        an_valid_nxt = push;
        out_data_nxt = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_valid_r   <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      an_valid_r   <= an_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign space      = !skid_valid_r;
  assign out_tvalid = an_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/dfa_string_matcher.sv
// dfa_string_matcher: top level of the table-driven dfa string matcher
// uses dfa_sm_pkg, dfa_sm_table and dfa_sm_out_buf
//
// Usage
//   Input channel in_*: in_tuser selects the request (write transition, mark
//   accepting, match character, match empty string), in_tdata carries the
//   state index, symbol and destination state, in_tlast marks the final character.
//   Output channel out_*: one result item per completed string or empty
//   string query, with accepted, bad_symbol and end_state.
//   Flow: table writes, marks, empty queries and characters that need no
//   lookup complete when taken; a character that walks the table moves to
//   S_LOOKUP with in_tready low until the registered read of the transition
//   memory returns the next state, so no new item is taken before then.
//   Results: a result goes into the registered output buffer; when its last
//   character needs a table lookup, it is pushed from S_LOOKUP.
//   Reset: a clearing pass writes all NUM_STATES * NUM_SYMBOLS table
//   entries (6016 by default) invalid with in_tready low;
//   accepting marks and the string state clear at once.
//   Stall: two results are buffered; while both wait, in_tready stays low.
`default_nettype none

module dfa_string_matcher #(
  parameter int NUM_STATES  = dfa_sm_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = dfa_sm_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // state_index[5:0], symbol[7:0], dest_state[5:0], zeros
  input  wire logic [1:0]  in_tuser,  // req_type[1:0]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata  // accepted, bad_symbol, end_state[5:0]
);

  localparam int DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MW    = $clog2(NUM_STATES);
  localparam int ST_W  = dfa_sm_pkg::ST_W;

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } fsm_t;

  fsm_t                          state_r, state_nxt;
  logic [ST_W-1:0]               cur_r, cur_nxt;
  logic                          dead_r, dead_nxt;
  logic                          bad_r, bad_nxt;
  logic                          last_r, last_nxt;
  logic [NUM_STATES-1:0]         marks_r, marks_nxt;

  dfa_sm_pkg::req_t              req;
  logic [ST_W-1:0]               sidx;
  logic [dfa_sm_pkg::SYM_W-1:0]  sym;
  logic [ST_W-1:0]               nxt;
  logic [dfa_sm_pkg::SYM_W-1:0]  sym_off;
  logic                          sym_ok, sidx_ok, nxt_ok;
  logic                          accept;
  logic [ST_W-1:0]               row;
  logic [AW-1:0]                 tbl_addr;
  dfa_sm_pkg::tbl_cmd_t          tbl_cmd;
  dfa_sm_pkg::tbl_entry_t        tbl_rdata;
  logic                          clr_busy;
  logic                          buf_space;
  logic                          push;
  dfa_sm_pkg::result_t           push_data;
  logic                          bad_v;
  logic                          lk_dead;

  // unpack the input item
  assign req  = dfa_sm_pkg::req_t'(in_tuser);
  assign sidx = in_tdata[5:0];
  assign sym  = in_tdata[13:6];
  assign nxt  = in_tdata[19:14];

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !clr_busy && buf_space;

  // range checks
  assign sym_off = sym - dfa_sm_pkg::SYM_BASE;
  assign sym_ok  = (sym >= dfa_sm_pkg::SYM_BASE) && (32'(sym_off) < NUM_SYMBOLS);
  assign sidx_ok = 32'(sidx) < NUM_STATES;
  assign nxt_ok  = 32'(nxt) < NUM_STATES;

  // table address: row of the written state or of the current state
  assign row      = (req == dfa_sm_pkg::REQ_WR_TRANS) ? sidx : cur_r;
  assign tbl_addr = AW'(row) * AW'(NUM_SYMBOLS) + AW'(sym_off);

  // table command
  always_comb begin
    tbl_cmd.we         = accept && (req == dfa_sm_pkg::REQ_WR_TRANS)
                         && sidx_ok && nxt_ok && sym_ok;
    tbl_cmd.re         = accept && (req == dfa_sm_pkg::REQ_MATCH) && sym_ok && !dead_r;
    tbl_cmd.wdata.valid = 1'b1;
    tbl_cmd.wdata.dest  = nxt;
  end

  assign lk_dead = !tbl_rdata.valid;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    dead_nxt  = dead_r;
    bad_nxt   = bad_r;
    last_nxt  = last_r;
    marks_nxt = marks_r;
    push      = 1'b0;
    push_data = '0;
    bad_v     = bad_r || !sym_ok;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req)
            dfa_sm_pkg::REQ_WR_TRANS: begin
              // handled by the table write port
            end
            dfa_sm_pkg::REQ_MARK: begin
              if (sidx_ok) begin
                marks_nxt[MW'(sidx)] = 1'b1;
              end
            end
            dfa_sm_pkg::REQ_EMPTY: begin
              push               = 1'b1;
              push_data.accepted = marks_r[0];
            end
            dfa_sm_pkg::REQ_MATCH: begin
              if (sym_ok && !dead_r) begin
                state_nxt = S_LOOKUP;
                last_nxt  = in_tlast;
              end else if (in_tlast) begin
                // dead or bad character closes the string with a reject
                push                 = 1'b1;
                push_data.bad_symbol = bad_v;
                cur_nxt              = '0;
                dead_nxt             = 1'b0;
                bad_nxt              = 1'b0;
              end else begin
                dead_nxt = 1'b1;
                bad_nxt  = bad_v;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOKUP: begin
        state_nxt = S_IDLE;
        if (last_r) begin
          push                 = 1'b1;
          push_data.accepted   = !lk_dead && marks_r[MW'(tbl_rdata.dest)];
          push_data.bad_symbol = bad_r;
          push_data.end_state  = lk_dead ? '0 : tbl_rdata.dest;
          cur_nxt              = '0;
          dead_nxt             = 1'b0;
          bad_nxt              = 1'b0;
        end else begin
          cur_nxt  = lk_dead ? cur_r : tbl_rdata.dest;
          dead_nxt = lk_dead;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      dead_r  <= 1'b0;
      bad_r   <= 1'b0;
      last_r  <= 1'b0;
      marks_r <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      dead_r  <= dead_nxt;
      bad_r   <= bad_nxt;
      last_r  <= last_nxt;
      marks_r <= marks_nxt;
    end
  end

  // transition table memory
  dfa_sm_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (tbl_cmd),
    .addr     (tbl_addr),
    .rdata    (tbl_rdata),
    .clr_busy (clr_busy)
  );

  // result buffering
  dfa_sm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .space      (buf_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> dv/tb_dfa_string_matcher.sv
// tb_dfa_string_matcher: self-checking testbench for the dfa string matcher
// directed table then random strings over a small alphabet, checked by a local predictor
// depends on rtl/dfa_sm_pkg.sv and rtl/dfa_string_matcher.sv
`timescale 1ns / 1ps

module tb_dfa_string_matcher;
  import dfa_sm_pkg::*;

  localparam int N_ST        = 64;
  localparam int N_SYM       = 94;
  localparam int ITEMS       = 1200;
  localparam int TAIL_CYCLES = 20;
  // clearing pass plus every item at its slowest, several times over
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIR       = 25;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  dfa_string_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: transition table, accepting marks, string walk
  bit        trans_ok   [N_ST][N_SYM];
  logic [5:0] trans_dest [N_ST][N_SYM];
  bit        accept_mark [N_ST];
  logic [5:0] walk_state = '0;
  bit        walk_dead  = 1'b0;
  bit        walk_bad   = 1'b0;

  result_t   match_results_q [$];
  int        mismatches  = 0;
  int        items_sent  = 0;
  int        cycle_count = 0;
  bit        tx_calm     = 1'b0;
  bit        rx_calm     = 1'b0;
  logic [7:0] alphabet [6];

  // directed stimulus row, expected result typed in where obvious
  typedef struct packed {
    req_t       req;
    logic [5:0] sidx;
    logic [7:0] sym;
    logic [5:0] nxt;
    logic       last;
    logic       typed;
    logic       acc;
    logic       bad;
    logic [5:0] fin;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    // nothing marked after reset
    '{REQ_EMPTY,    6'd0,  8'h00, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 6'd0},
    // unwritten transition kills the walk
    '{REQ_MATCH,    6'd0,  8'h61, 6'd0,  1'b1, 1'b1, 1'b0, 1'b0, 6'd0},
    // bytes outside the printable range
    '{REQ_MATCH,    6'd63, 8'h00, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1, 6'd0},
    '{REQ_MATCH,    6'd0,  8'hFF, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h7E, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1, 6'd0},
    // one good write, two ignored writes with bad symbols
    '{REQ_WR_TRANS, 6'd0,  8'h61, 6'd1,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_WR_TRANS, 6'd0,  8'h1F, 6'd5,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_WR_TRANS, 6'd0,  8'h7E, 6'd5,  1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MARK,     6'd1,  8'hFF, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h61, 6'd0,  1'b1, 1'b1, 1'b1, 1'b0, 6'd1},
    // marking state 0 makes the empty string accepted
    '{REQ_MARK,     6'd0,  8'h00, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_EMPTY,    6'd63, 8'hFF, 6'd63, 1'b0, 1'b1, 1'b1, 1'b0, 6'd0},
    // longer path through the extreme states
    '{REQ_WR_TRANS, 6'd1,  8'h62, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_WR_TRANS, 6'd63, 8'h7D, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    // empty query in the middle of a string leaves it alone
    '{REQ_EMPTY,    6'd0,  8'h00, 6'd0,  1'b1, 1'b1, 1'b1, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h62, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h7D, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 6'd0},
    // bad byte in mid string kills the walk, string ends rejected with bad_symbol
    '{REQ_MATCH,    6'd0,  8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'hFF, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h62, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1, 6'd0},
    // writes land between characters of a string
    '{REQ_MATCH,    6'd0,  8'h61, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_WR_TRANS, 6'd1,  8'h20, 6'd2,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MARK,     6'd2,  8'h20, 6'd0,  1'b0, 1'b0, 1'b0, 1'b0, 6'd0},
    '{REQ_MATCH,    6'd0,  8'h20, 6'd0,  1'b1, 1'b0, 1'b0, 1'b0, 6'd0}
  };

  function automatic bit printable(logic [7:0] s);
    return (s >= SYM_BASE) && (int'(s - SYM_BASE) < N_SYM);
  endfunction

  // advance the predicted matcher by one item
  task automatic step_matcher(input req_t req, input logic [5:0] sidx,
                              input logic [7:0] sym, input logic [5:0] nxt,
                              input logic last, output bit gives, output result_t res);
    int col;
    col   = int'(sym) - int'(SYM_BASE);
    gives = 1'b0;
    res   = '0;
    case (req)
      REQ_WR_TRANS: begin
        if (printable(sym)) begin
          trans_ok[sidx][col]   = 1'b1;
          trans_dest[sidx][col] = nxt;
        end
      end
      REQ_MARK: begin
        accept_mark[sidx] = 1'b1;
      end
      REQ_EMPTY: begin
        gives          = 1'b1;
        res.accepted   = accept_mark[0];
      end
      default: begin
        if (!printable(sym)) begin
          walk_bad  = 1'b1;
          walk_dead = 1'b1;
        end else if (!walk_dead) begin
          if (trans_ok[walk_state][col]) walk_state = trans_dest[walk_state][col];
          else walk_dead = 1'b1;
        end
        if (last) begin
          gives          = 1'b1;
          res.accepted   = !walk_dead && accept_mark[walk_state];
          res.bad_symbol = walk_bad;
          res.end_state  = walk_dead ? 6'd0 : walk_state;
          walk_state     = '0;
          walk_dead      = 1'b0;
          walk_bad       = 1'b0;
        end
      end
    endcase
  endtask

  // drive one item from a falling edge, return at the falling edge after acceptance
  task automatic send_item(input req_t req, input logic [5:0] sidx, input logic [7:0] sym,
                           input logic [5:0] nxt, input logic last,
                           input bit typed, input result_t typed_res);
    int      gap;
    bit      gives;
    result_t res;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0000, nxt, sym, sidx};
    in_tuser  = req;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    step_matcher(req, sidx, sym, nxt, last, gives, res);
    if (gives) match_results_q.push_back(typed ? typed_res : res);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every expected result has come out
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (match_results_q.size() != 0) @(negedge clk);
  endtask

  // mostly the small working set of states, sometimes any state
  function automatic logic [5:0] pick_state();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, 15));
  endfunction

  // mostly the alphabet, some other printable, a few arbitrary bytes
  function automatic logic [7:0] pick_sym();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return alphabet[$urandom_range(0, 5)];
    if (r < 94) return 8'($urandom_range(32, 125));
    return 8'($urandom_range(0, 255));
  endfunction

  // run limit
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[dfa_string_matcher] ERROR");
      $finish;
    end
  end

  // result side: random stalls, compare with the oldest expectation
  initial begin
    int      stall;
    result_t got;
    result_t want;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        out_tready = 1'b0;
        @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata;
      if (match_results_q.size() == 0) begin
        $error("result with none expected: %h", out_tdata);
        mismatches++;
      end else begin
        want = match_results_q.pop_front();
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          mismatches++;
        end
        if (got.bad_symbol !== want.bad_symbol) begin
          $error("bad_symbol: expected %0d, got %0d", want.bad_symbol, got.bad_symbol);
          mismatches++;
        end
        if (got.end_state !== want.end_state) begin
          $error("end_state: expected %0d, got %0d", want.end_state, got.end_state);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    result_t typed_res;
    int      r;
    int      len;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int i = 0; i < N_DIR; i++) begin
      typed_res.accepted   = dir_rows[i].acc;
      typed_res.bad_symbol = dir_rows[i].bad;
      typed_res.end_state  = dir_rows[i].fin;
      send_item(dir_rows[i].req, dir_rows[i].sidx, dir_rows[i].sym, dir_rows[i].nxt,
                dir_rows[i].last, dir_rows[i].typed, typed_res);
    end
    drain_results();

    // alphabet for the random strings, with both range ends in it
    alphabet[0] = 8'd32;
    alphabet[5] = 8'd125;
    for (int i = 1; i < 5; i++) alphabet[i] = 8'($urandom_range(33, 124));

    // seed the table over the working set
    repeat (48) begin
      send_item(REQ_WR_TRANS, 6'($urandom_range(0, 15)), alphabet[$urandom_range(0, 5)],
                6'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0, '0);
    end

    // random mix: mostly strings, some writes, marks and empty queries
    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 99) == 0) drain_results();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_item(REQ_WR_TRANS, pick_state(), pick_sym(), pick_state(),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (r < 12) begin
        send_item(REQ_MARK, pick_state(), 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (r < 16) begin
        send_item(REQ_EMPTY, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                  6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          // occasional write or empty query inside the string
          if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1) == 0)
              send_item(REQ_WR_TRANS, pick_state(), pick_sym(), pick_state(),
                        1'($urandom_range(0, 1)), 1'b0, '0);
            else
              send_item(REQ_EMPTY, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                        6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), 1'b0, '0);
          end
          send_item(REQ_MATCH, 6'($urandom_range(0, 63)), pick_sym(),
                    6'($urandom_range(0, 63)), k == len - 1, 1'b0, '0);
        end
      end
    end

    // wind down
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[dfa_string_matcher] OK");
    end else begin
      $display("[dfa_string_matcher] ERROR");
    end
    $finish;
  end

endmodule
